FILE: rtl/core/sas_pkg.sv
// Shared types and constants for the store address sequencer.
package sas_pkg;

    localparam int BYTE_BITS = 8;
    localparam int ADDR_BITS = 2 * BYTE_BITS;

    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_bus_op;

    typedef enum logic [2:0] {
        MODE_ZP    = 3'd0,
        MODE_ZP_X  = 3'd1,
        MODE_IND_X = 3'd2,
        MODE_IND_Y = 3'd3,
        MODE_ABS   = 3'd4,
        MODE_ABS_X = 3'd5,
        MODE_ABS_Y = 3'd6,
        MODE_NONE  = 3'd7
    } t_mode;

    localparam logic KIND_START = 1'b0;

    typedef struct packed {
        logic [2:0]           phase;
        t_mode                held_mode;
        logic [BYTE_BITS-1:0] zp_pointer;
        logic [ADDR_BITS-1:0] effective_address;
    } t_seq_state;

    typedef struct packed {
        logic [ADDR_BITS-1:0] bus_address;
        t_bus_op              bus_op;
        logic [BYTE_BITS-1:0] write_data;
        logic                 pc_advance;
        logic                 done_res;
    } t_bus_word;

endpackage

FILE: rtl/core/sas_step.sv
// Next-state and bus word logic for one bus cycle of the sequencer.
module sas_step
    import sas_pkg::*;
(
    input  t_seq_state           i_state,
    input  logic                 i_kind,
    input  logic [2:0]           i_mode,
    input  logic [ADDR_BITS-1:0] i_program_counter,
    input  logic [BYTE_BITS-1:0] i_index_x,
    input  logic [BYTE_BITS-1:0] i_index_y,
    input  logic [BYTE_BITS-1:0] i_accumulator,
    input  logic [BYTE_BITS-1:0] i_read_data,
    output t_seq_state           o_state,
    output t_bus_word            o_word
);

    logic [ADDR_BITS-1:0] hi;
    logic [ADDR_BITS-1:0] ea_hi;
    logic [2:0]           cyc;
    logic [BYTE_BITS-1:0] idx;

    assign hi    = {i_read_data, {BYTE_BITS{1'b0}}};
    assign ea_hi = i_state.effective_address | hi;
    assign cyc   = i_state.phase + 3'd1;
    assign idx   = (i_state.held_mode == MODE_ABS_X) ? i_index_x : i_index_y;

    always_comb begin
        o_state = i_state;
        o_word  = '{bus_address: '0, bus_op: OP_IDLE, write_data: '0,
                    pc_advance: 1'b0, done_res: 1'b0};
        if (i_kind == KIND_START) begin
            if (t_mode'(i_mode) == MODE_NONE) begin
                o_state.phase = 3'd0;
            end else begin
                o_state.held_mode         = t_mode'(i_mode);
                o_state.phase             = 3'd1;
                o_state.zp_pointer        = '0;
                o_state.effective_address = '0;
                o_word.bus_address        = i_program_counter;
                o_word.bus_op             = OP_READ;
                o_word.pc_advance         = 1'b1;
            end
        end else if (i_state.phase != 3'd0) begin
            o_state.phase = cyc;
            unique case (i_state.held_mode)
                MODE_ZP: begin
                    o_state.effective_address = {{BYTE_BITS{1'b0}}, i_read_data};
                    o_state.phase             = 3'd0;
                end
                MODE_ZP_X: begin
                    if (cyc == 3'd2) begin
                        o_state.zp_pointer = i_read_data + i_index_x;
                    end else begin
                        o_state.effective_address =
                            {{BYTE_BITS{1'b0}}, i_state.zp_pointer};
                        o_state.phase = 3'd0;
                    end
                end
                MODE_IND_X: begin
                    if (cyc == 3'd2) begin
                        o_state.zp_pointer = i_read_data;
                    end else if (cyc == 3'd3) begin
                        o_state.zp_pointer = i_state.zp_pointer + i_index_x;
                    end else if (cyc == 3'd4) begin
                        o_word.bus_address = {{BYTE_BITS{1'b0}}, i_state.zp_pointer};
                        o_word.bus_op      = OP_READ;
                        o_state.zp_pointer = i_state.zp_pointer + 8'd1;
                    end else if (cyc == 3'd5) begin
                        o_state.effective_address = {{BYTE_BITS{1'b0}}, i_read_data};
                        o_word.bus_address = {{BYTE_BITS{1'b0}}, i_state.zp_pointer};
                        o_word.bus_op      = OP_READ;
                    end else begin
                        o_state.effective_address = ea_hi;
                        o_state.phase             = 3'd0;
                    end
                end
                MODE_IND_Y: begin
                    if (cyc == 3'd2) begin
                        o_state.zp_pointer = i_read_data;
                    end else if (cyc == 3'd3) begin
                        o_word.bus_address = {{BYTE_BITS{1'b0}}, i_state.zp_pointer};
                        o_word.bus_op      = OP_READ;
                        o_state.zp_pointer = i_state.zp_pointer + 8'd1;
                    end else if (cyc == 3'd4) begin
                        o_state.effective_address = {{BYTE_BITS{1'b0}}, i_read_data};
                        o_word.bus_address = {{BYTE_BITS{1'b0}}, i_state.zp_pointer};
                        o_word.bus_op      = OP_READ;
                    end else if (cyc == 3'd5) begin
                        o_state.effective_address =
                            ea_hi + {{BYTE_BITS{1'b0}}, i_index_y};
                    end else begin
                        o_state.phase = 3'd0;
                    end
                end
                default: begin
                    if (cyc == 3'd2) begin
                        o_state.effective_address = {{BYTE_BITS{1'b0}}, i_read_data};
                        o_word.bus_address = i_program_counter;
                        o_word.bus_op      = OP_READ;
                        o_word.pc_advance  = 1'b1;
                    end else if (cyc == 3'd3 && i_state.held_mode != MODE_ABS) begin
                        o_state.effective_address = ea_hi + {{BYTE_BITS{1'b0}}, idx};
                    end else begin
                        if (i_state.held_mode == MODE_ABS) begin
                            o_state.effective_address = ea_hi;
                        end
                        o_state.phase = 3'd0;
                    end
                end
            endcase
            if (o_state.phase == 3'd0) begin
                o_word.bus_address = o_state.effective_address;
                o_word.bus_op      = OP_WRITE;
                o_word.write_data  = i_accumulator;
                o_word.done_res    = 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/store_address_sequencer_top.sv
// Top level of the store address sequencer: state and bus word registers.
// The bus word for an accepted item is registered and valid in the cycle after acceptance.
// Throughput: one item per cycle; the step logic is a single pass over the state.
// A full output register stalls input only while its word is not taken.
// Reset clears sequencer state to idle and empties the output register.
module store_address_sequencer_top
    import sas_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_kind,
    input  logic [2:0]           i_mode,
    input  logic [ADDR_BITS-1:0] i_program_counter,
    input  logic [BYTE_BITS-1:0] i_index_x,
    input  logic [BYTE_BITS-1:0] i_index_y,
    input  logic [BYTE_BITS-1:0] i_accumulator,
    input  logic [BYTE_BITS-1:0] i_read_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ADDR_BITS-1:0] o_bus_address,
    output logic [1:0]           o_bus_op,
    output logic [BYTE_BITS-1:0] o_write_data,
    output logic                 o_pc_advance,
    output logic                 o_done_res
);

    t_seq_state r_state;
    t_seq_state n_state;
    t_bus_word  r_word;
    t_bus_word  n_word;
    logic       r_out_valid;
    logic       accept;

    sas_step u_step (
        .i_state           (r_state),
        .i_kind            (i_kind),
        .i_mode            (i_mode),
        .i_program_counter (i_program_counter),
        .i_index_x         (i_index_x),
        .i_index_y         (i_index_y),
        .i_accumulator     (i_accumulator),
        .i_read_data       (i_read_data),
        .o_state           (n_state),
        .o_word            (n_word)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{phase: 3'd0, held_mode: MODE_ZP, zp_pointer: '0,
                             effective_address: '0};
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= n_word;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_bus_address = r_word.bus_address;
    assign o_bus_op      = r_word.bus_op;
    assign o_write_data  = r_word.write_data;
    assign o_pc_advance  = r_word.pc_advance;
    assign o_done_res    = r_word.done_res;

endmodule

FILE: verif/store_address_sequencer_top_test.sv
// Self-checking testbench for the store address sequencer: predicts every bus word per step.
module store_address_sequencer_top_test
    import sas_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_ADVANCE = ~KIND_START;
    localparam int   RANDOM_WORDS = 1350;
    localparam int   HOLD_CYCLES  = 60;
    localparam int   SETTLE       = 4;

    typedef struct packed {
        logic                 kind;
        logic [2:0]           mode;
        logic [ADDR_BITS-1:0] pc;
        logic [BYTE_BITS-1:0] x;
        logic [BYTE_BITS-1:0] y;
        logic [BYTE_BITS-1:0] acc;
        logic [BYTE_BITS-1:0] rd;
    } t_step_word;

    class bus_word_tracker;
        logic [2:0]           seq_phase;
        t_mode                seq_mode;
        logic [BYTE_BITS-1:0] pointer;
        logic [ADDR_BITS-1:0] target;
        t_bus_word            expected_words[$];
        int                   mismatches;

        function new();
            seq_phase  = '0;
            seq_mode   = MODE_ZP;
            pointer    = '0;
            target     = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
            mismatches++;
        endtask

        function void note_step(t_step_word s);
            t_bus_word            w;
            logic [3:0]           cyc;
            logic [ADDR_BITS-1:0] hi;
            w  = '0;
            w.bus_op = OP_IDLE;
            hi = {s.rd, 8'h00};
            if (s.kind == KIND_START) begin
                if (s.mode == MODE_NONE) begin
                    seq_phase = '0;
                end else begin
                    seq_mode     = t_mode'(s.mode);
                    seq_phase    = 3'd1;
                    pointer      = '0;
                    target       = '0;
                    w.bus_address = s.pc;
                    w.bus_op     = OP_READ;
                    w.pc_advance = 1'b1;
                end
            end else if (seq_phase != 0) begin
                cyc       = {1'b0, seq_phase} + 4'd1;
                seq_phase = cyc[2:0];
                case (seq_mode)
                    MODE_ZP: begin
                        target    = {8'h00, s.rd};
                        seq_phase = '0;
                    end
                    MODE_ZP_X: begin
                        if (cyc == 2) begin
                            pointer = s.rd + s.x;
                        end else begin
                            target    = {8'h00, pointer};
                            seq_phase = '0;
                        end
                    end
                    MODE_IND_X: begin
                        if (cyc == 2) begin
                            pointer = s.rd;
                        end else if (cyc == 3) begin
                            pointer = pointer + s.x;
                        end else if (cyc == 4) begin
                            w.bus_address = {8'h00, pointer};
                            w.bus_op      = OP_READ;
                            pointer       = pointer + 8'd1;
                        end else if (cyc == 5) begin
                            target        = {8'h00, s.rd};
                            w.bus_address = {8'h00, pointer};
                            w.bus_op      = OP_READ;
                        end else begin
                            target    = target | hi;
                            seq_phase = '0;
                        end
                    end
                    MODE_IND_Y: begin
                        if (cyc == 2) begin
                            pointer = s.rd;
                        end else if (cyc == 3) begin
                            w.bus_address = {8'h00, pointer};
                            w.bus_op      = OP_READ;
                            pointer       = pointer + 8'd1;
                        end else if (cyc == 4) begin
                            target        = {8'h00, s.rd};
                            w.bus_address = {8'h00, pointer};
                            w.bus_op      = OP_READ;
                        end else if (cyc == 5) begin
                            target = (target | hi) + {8'h00, s.y};
                        end else begin
                            seq_phase = '0;
                        end
                    end
                    default: begin
                        if (cyc == 2) begin
                            target        = {8'h00, s.rd};
                            w.bus_address = s.pc;
                            w.bus_op      = OP_READ;
                            w.pc_advance  = 1'b1;
                        end else if (cyc == 3 && seq_mode != MODE_ABS) begin
                            target = (target | hi)
                                   + {8'h00, (seq_mode == MODE_ABS_X) ? s.x : s.y};
                        end else begin
                            if (seq_mode == MODE_ABS)
                                target = target | hi;
                            seq_phase = '0;
                        end
                    end
                endcase
                if (seq_phase == 0) begin
                    w.bus_address = target;
                    w.bus_op      = OP_WRITE;
                    w.write_data  = s.acc;
                    w.done_res    = 1'b1;
                end
            end
            expected_words.push_back(w);
        endfunction

        task check_word(t_bus_word got);
            t_bus_word want;
            if (expected_words.size() == 0) begin
                flag_mismatch("unexpected word", got, '0);
                return;
            end
            want = expected_words.pop_front();
            if (got.bus_address !== want.bus_address)
                flag_mismatch("bus_address", got.bus_address, want.bus_address);
            if (got.bus_op !== want.bus_op)
                flag_mismatch("bus_op", got.bus_op, want.bus_op);
            if (got.write_data !== want.write_data)
                flag_mismatch("write_data", got.write_data, want.write_data);
            if (got.pc_advance !== want.pc_advance)
                flag_mismatch("pc_advance", got.pc_advance, want.pc_advance);
            if (got.done_res !== want.done_res)
                flag_mismatch("done_res", got.done_res, want.done_res);
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_kind;
    logic [2:0]           i_mode;
    logic [ADDR_BITS-1:0] i_program_counter;
    logic [BYTE_BITS-1:0] i_index_x;
    logic [BYTE_BITS-1:0] i_index_y;
    logic [BYTE_BITS-1:0] i_accumulator;
    logic [BYTE_BITS-1:0] i_read_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [ADDR_BITS-1:0] o_bus_address;
    logic [1:0]           o_bus_op;
    logic [BYTE_BITS-1:0] o_write_data;
    logic                 o_pc_advance;
    logic                 o_done_res;

    bus_word_tracker tracker = new();
    int              words_sent = 0;
    bit              no_gaps = 1'b0;
    bit              hold_req = 1'b0;

    store_address_sequencer_top i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_kind            (i_kind),
        .i_mode            (i_mode),
        .i_program_counter (i_program_counter),
        .i_index_x         (i_index_x),
        .i_index_y         (i_index_y),
        .i_accumulator     (i_accumulator),
        .i_read_data       (i_read_data),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_bus_address     (o_bus_address),
        .o_bus_op          (o_bus_op),
        .o_write_data      (o_write_data),
        .o_pc_advance      (o_pc_advance),
        .o_done_res        (o_done_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_bus_word  got;
        t_step_word taken;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.bus_address = o_bus_address;
            got.bus_op      = t_bus_op'(o_bus_op);
            got.write_data  = o_write_data;
            got.pc_advance  = o_pc_advance;
            got.done_res    = o_done_res;
            tracker.check_word(got);
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            taken = '{i_kind, i_mode, i_program_counter, i_index_x, i_index_y,
                      i_accumulator, i_read_data};
            tracker.note_step(taken);
        end
    end

    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_ready <= no_gaps || ($urandom_range(99) >= 34);
            end
        end
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic t_step_word step(logic kind, logic [2:0] mode,
                                        logic [15:0] pc, logic [7:0] x, logic [7:0] y,
                                        logic [7:0] acc, logic [7:0] rd);
        return '{kind, mode, pc, x, y, acc, rd};
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic t_step_word rand_step(logic kind, logic [2:0] mode);
        logic [15:0] pc;
        pc = ($urandom_range(9) == 0) ? {16{1'($urandom)}} : 16'($urandom);
        return '{kind, mode, pc, rand_byte(), rand_byte(), rand_byte(), rand_byte()};
    endfunction

    task automatic send_word(t_step_word s);
        while (!no_gaps && $urandom_range(99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_kind            <= s.kind;
        i_mode            <= s.mode;
        i_program_counter <= s.pc;
        i_index_x         <= s.x;
        i_index_y         <= s.y;
        i_accumulator     <= s.acc;
        i_read_data       <= s.rd;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_instruction(t_mode m, int advances);
        send_word(rand_step(KIND_START, m));
        repeat (advances) send_word(rand_step(KIND_ADVANCE, 3'($urandom_range(7))));
    endtask

    initial begin
        t_mode m;
        int    full;
        int    r;
        int    base;
        bit    hold_done;
        bit    drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_kind            <= KIND_START;
        i_mode            <= MODE_ZP;
        i_program_counter <= '0;
        i_index_x         <= '0;
        i_index_y         <= '0;
        i_accumulator     <= '0;
        i_read_data       <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drop an advance while idle and a start with no mode
        send_word(step(KIND_ADVANCE, MODE_ABS, 16'h1234, 8'h11, 8'h22, 8'h33, 8'h44));
        send_word(step(KIND_START, MODE_NONE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_word(step(KIND_START, MODE_ZP, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00));
        send_word(step(KIND_ADVANCE, MODE_ZP, 16'h0001, 8'h00, 8'h00, 8'hFF, 8'hFF));
        send_word(step(KIND_START, MODE_ZP_X, 16'hFFFF, 8'hFF, 8'h00, 8'h00, 8'h00));
        send_word(step(KIND_ADVANCE, MODE_ZP_X, 16'h0000, 8'hFF, 8'h00, 8'h00, 8'hFF));
        send_word(step(KIND_ADVANCE, MODE_ZP_X, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00));
        send_word(step(KIND_START, MODE_IND_X, 16'h8000, 8'h01, 8'h00, 8'hA5, 8'h00));
        send_word(step(KIND_ADVANCE, MODE_IND_X, 16'h8001, 8'h01, 8'h00, 8'hA5, 8'hFF));
        send_word(step(KIND_ADVANCE, MODE_IND_X, 16'h8001, 8'h01, 8'h00, 8'hA5, 8'h00));
        send_word(step(KIND_ADVANCE, MODE_IND_X, 16'h8001, 8'h01, 8'h00, 8'hA5, 8'h00));
        send_word(step(KIND_ADVANCE, MODE_IND_X, 16'h8001, 8'h01, 8'h00, 8'hA5, 8'hFF));
        send_word(step(KIND_ADVANCE, MODE_IND_X, 16'h8001, 8'h01, 8'h00, 8'hA5, 8'hFF));
        send_word(step(KIND_START, MODE_IND_Y, 16'h7FFF, 8'h00, 8'hFF, 8'h5A, 8'h00));
        send_word(step(KIND_ADVANCE, MODE_IND_Y, 16'h8000, 8'h00, 8'hFF, 8'h5A, 8'hFF));
        send_word(step(KIND_ADVANCE, MODE_IND_Y, 16'h8000, 8'h00, 8'hFF, 8'h5A, 8'h00));
        send_word(step(KIND_ADVANCE, MODE_IND_Y, 16'h8000, 8'h00, 8'hFF, 8'h5A, 8'hFF));
        send_word(step(KIND_ADVANCE, MODE_IND_Y, 16'h8000, 8'h00, 8'hFF, 8'h5A, 8'hFF));
        send_word(step(KIND_ADVANCE, MODE_IND_Y, 16'h8000, 8'h00, 8'hFF, 8'h5A, 8'h00));
        send_word(step(KIND_START, MODE_ABS, 16'hFFFE, 8'h00, 8'h00, 8'h00, 8'h00));
        send_word(step(KIND_ADVANCE, MODE_ABS, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00));
        send_word(step(KIND_ADVANCE, MODE_ABS, 16'h0000, 8'h00, 8'h00, 8'h80, 8'hFF));
        send_word(step(KIND_START, MODE_ABS_X, 16'h4000, 8'h01, 8'h00, 8'h00, 8'h00));
        send_word(step(KIND_ADVANCE, MODE_ABS_X, 16'h4001, 8'h01, 8'h00, 8'h00, 8'hFF));
        send_word(step(KIND_ADVANCE, MODE_ABS_X, 16'h4002, 8'h01, 8'h00, 8'h00, 8'hFF));
        send_word(step(KIND_ADVANCE, MODE_ABS_X, 16'h4002, 8'h01, 8'h00, 8'h01, 8'h00));
        // abandon abs Y halfway with a fresh zero page store
        send_word(step(KIND_START, MODE_ABS_Y, 16'h2000, 8'h00, 8'h10, 8'h00, 8'h00));
        send_word(step(KIND_ADVANCE, MODE_ABS_Y, 16'h2001, 8'h00, 8'h10, 8'h00, 8'h34));
        send_word(step(KIND_START, MODE_ZP, 16'h3000, 8'h00, 8'h00, 8'h00, 8'h12));
        send_word(step(KIND_ADVANCE, MODE_ZP, 16'h3001, 8'h00, 8'h00, 8'h77, 8'h80));

        base = words_sent;
        while (words_sent - base < RANDOM_WORDS) begin
            no_gaps = (words_sent - base >= 700) && (words_sent - base < 900);
            if (!hold_done && words_sent - base >= 300) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && words_sent - base >= 500) begin
                drain_results();
                drain_done = 1'b1;
            end
            m    = t_mode'($urandom_range(6));
            full = (m == MODE_ZP) ? 1 :
                   (m == MODE_ZP_X || m == MODE_ABS) ? 2 :
                   (m == MODE_ABS_X || m == MODE_ABS_Y) ? 3 : 5;
            r = $urandom_range(99);
            if (r < 80)
                run_instruction(m, full);
            else if (r < 88)
                run_instruction(m, $urandom_range(full - 1));
            else if (r < 92)
                run_instruction(m, full + $urandom_range(2, 1));
            else if (r < 96)
                send_word(rand_step(KIND_ADVANCE, 3'($urandom_range(7))));
            else
                send_word(rand_step(KIND_START, MODE_NONE));
        end
        no_gaps = 1'b0;

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/sas_pkg.sv
rtl/core/sas_step.sv
rtl/core/store_address_sequencer_top.sv
verif/store_address_sequencer_top_test.sv
